>>> hw/rtl/imu_sfp_pkg.sv
// Shared types and constants for the inertial sensor serial frame parser.
`default_nettype none
package imu_sfp_pkg;

  // Frame bytes
  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_RATE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;
  localparam logic [7:0] TYPE_QUAT  = 8'h59;

  // Reported frame types
  localparam logic [2:0] FT_ACCEL = 3'd0;
  localparam logic [2:0] FT_RATE  = 3'd1;
  localparam logic [2:0] FT_ANGLE = 3'd2;
  localparam logic [2:0] FT_QUAT  = 3'd3;
  localparam logic [2:0] FT_NONE  = 3'd4;

  // Internal two-bit type codes
  localparam logic [1:0] TC_ACCEL = 2'd0;
  localparam logic [1:0] TC_RATE  = 2'd1;
  localparam logic [1:0] TC_ANGLE = 2'd2;
  localparam logic [1:0] TC_QUAT  = 2'd3;

  // Parse positions
  localparam logic [3:0] POS_HUNT      = 4'd0;
  localparam logic [3:0] POS_TYPE      = 4'd1;
  localparam logic [3:0] POS_PAY_FIRST = 4'd2;
  localparam logic [3:0] POS_PAY_LAST  = 4'd9;
  localparam logic [3:0] POS_CHECK     = 4'd10;

  // Set flag per tracked frame type
  typedef enum logic [1:0] {
    FLAG_NONE = 2'd0,
    FLAG_GOOD = 2'd1,
    FLAG_BAD  = 2'd2
  } flag_t;

  // Set status codes
  localparam logic [1:0] STATUS_GOOD     = 2'd0;
  localparam logic [1:0] STATUS_DATA_ERR = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT  = 2'd2;

  localparam int NUM_SET = 3;

  // Configuration
  localparam int          PADDR_W        = 3;
  localparam int          PDATA_W        = 32;
  localparam logic        REG_TIMEOUT    = 1'b0;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd100;

  // Queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = QPTR_W + 1;
  localparam logic [QCNT_W-1:0] QDEPTH_CNT = QCNT_W'(QDEPTH);

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        frame_type;
    logic              frame_ok;
    logic signed [15:0] word_a;
    logic signed [15:0] word_b;
    logic signed [15:0] word_c;
    logic signed [15:0] word_d;
    logic              set_done;
    logic [1:0]        set_status;
  } out_item_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic       is_tick;
    logic       is_hdr;
    logic       type_known;
    logic [1:0] type_code;
    logic [7:0] data;
  } cls_item_t;

endpackage
`default_nettype wire

>>> hw/rtl/imu_sfp_front.sv
// Front end: accepts input transfers and classifies each byte.
`default_nettype none
module imu_sfp_front (
  input  wire logic                  in_valid,
  input  wire imu_sfp_pkg::in_item_t in_item,
  output logic                       in_stall,
  input  wire logic                  q_full,
  output logic                       push,
  output imu_sfp_pkg::cls_item_t     push_item
);

  // Hold the sender while the queue is full
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Classify the byte against header and type codes
  always_comb begin
    push_item            = '0;
    push_item.is_tick    = in_item.kind;
    push_item.data       = in_item.rx_byte;
    push_item.is_hdr     = (in_item.rx_byte == imu_sfp_pkg::HDR_BYTE);
    push_item.type_known = 1'b1;
    case (in_item.rx_byte)
      imu_sfp_pkg::TYPE_ACCEL: push_item.type_code = imu_sfp_pkg::TC_ACCEL;
      imu_sfp_pkg::TYPE_RATE:  push_item.type_code = imu_sfp_pkg::TC_RATE;
      imu_sfp_pkg::TYPE_ANGLE: push_item.type_code = imu_sfp_pkg::TC_ANGLE;
      imu_sfp_pkg::TYPE_QUAT:  push_item.type_code = imu_sfp_pkg::TC_QUAT;
      default: begin
        push_item.type_code  = imu_sfp_pkg::TC_ACCEL;
        push_item.type_known = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/imu_sfp_queue.sv
// Short queue of classified items between front and back.
`default_nettype none
module imu_sfp_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire imu_sfp_pkg::cls_item_t push_item,
  output logic                        full,
  output logic                        head_valid,
  output imu_sfp_pkg::cls_item_t      head_item,
  input  wire logic                   pop
);

  imu_sfp_pkg::cls_item_t            entries [imu_sfp_pkg::QDEPTH];
  logic [imu_sfp_pkg::QPTR_W-1:0]    wr_ptr;
  logic [imu_sfp_pkg::QPTR_W-1:0]    rd_ptr;
  logic [imu_sfp_pkg::QCNT_W-1:0]    count;
  logic                              do_pop;

  assign full       = (count == imu_sfp_pkg::QDEPTH_CNT);
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/imu_sfp_back.sv
// Back end: frame parser state, set tracking, timeout and result register.
`default_nettype none
module imu_sfp_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [15:0]            timeout_ticks,
  input  wire logic                   head_valid,
  input  wire imu_sfp_pkg::cls_item_t head_item,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output imu_sfp_pkg::out_item_t      out_item
);

  logic [3:0]             pos;
  logic [3:0]             pos_next;
  logic [1:0]             cur_type;
  logic [1:0]             cur_type_next;
  logic [7:0]             sum;
  logic [7:0]             sum_next;
  logic [15:0]            tick_count;
  logic [15:0]            tick_count_next;
  logic [7:0]             payload [8];
  imu_sfp_pkg::flag_t     flags [imu_sfp_pkg::NUM_SET];
  imu_sfp_pkg::flag_t     flags_next [imu_sfp_pkg::NUM_SET];
  logic                   pay_we;
  logic [3:0]             pay_off;
  logic                   res_valid;
  imu_sfp_pkg::out_item_t res;
  logic                   chk_ok;
  logic                   all_seen;
  logic                   all_good;

  // Step one item whenever the result register can take a new value
  assign pop     = head_valid && (!out_valid || !out_stall);
  assign pay_off = pos - imu_sfp_pkg::POS_PAY_FIRST;
  assign chk_ok  = (head_item.data == sum);

  always_comb begin
    pos_next        = pos;
    cur_type_next   = cur_type;
    sum_next        = sum;
    tick_count_next = tick_count;
    flags_next      = flags;
    pay_we          = 1'b0;
    res_valid       = 1'b0;
    res             = '0;
    all_seen        = 1'b0;
    all_good        = 1'b0;

    if (head_item.is_tick) begin
      // Timer tick: time out the set or count up
      if (tick_count >= timeout_ticks) begin
        res_valid       = 1'b1;
        res.frame_type  = imu_sfp_pkg::FT_NONE;
        res.set_done    = 1'b1;
        res.set_status  = imu_sfp_pkg::STATUS_TIMEOUT;
        tick_count_next = '0;
        for (int i = 0; i < imu_sfp_pkg::NUM_SET; i++) begin
          flags_next[i] = imu_sfp_pkg::FLAG_NONE;
        end
      end else begin
        tick_count_next = tick_count + 16'd1;
      end
    end else begin
      case (pos)
        imu_sfp_pkg::POS_HUNT: begin
          if (head_item.is_hdr) begin
            pos_next = imu_sfp_pkg::POS_TYPE;
            sum_next = imu_sfp_pkg::HDR_BYTE;
          end
        end
        imu_sfp_pkg::POS_TYPE: begin
          if (head_item.type_known) begin
            cur_type_next = head_item.type_code;
            sum_next      = sum + head_item.data;
            pos_next      = imu_sfp_pkg::POS_PAY_FIRST;
          end else if (head_item.is_hdr) begin
            pos_next = imu_sfp_pkg::POS_TYPE;
            sum_next = imu_sfp_pkg::HDR_BYTE;
          end else begin
            pos_next = imu_sfp_pkg::POS_HUNT;
          end
        end
        default: begin
          if (pos inside {[imu_sfp_pkg::POS_PAY_FIRST:imu_sfp_pkg::POS_PAY_LAST]}) begin
            // Payload byte
            pay_we   = 1'b1;
            sum_next = sum + head_item.data;
            pos_next = pos + 4'd1;
          end else begin
            // Checksum byte: report the frame
            pos_next       = imu_sfp_pkg::POS_HUNT;
            res_valid      = 1'b1;
            res.frame_type = {1'b0, cur_type};
            res.frame_ok   = chk_ok;
            res.word_a     = $signed({payload[1], payload[0]});
            res.word_b     = $signed({payload[3], payload[2]});
            res.word_c     = $signed({payload[5], payload[4]});
            res.word_d     = $signed({payload[7], payload[6]});
            if (cur_type != imu_sfp_pkg::TC_QUAT) begin
              for (int i = 0; i < imu_sfp_pkg::NUM_SET; i++) begin
                if (cur_type == 2'(i)) begin
                  flags_next[i] = chk_ok ? imu_sfp_pkg::FLAG_GOOD : imu_sfp_pkg::FLAG_BAD;
                end
              end
              all_seen = 1'b1;
              all_good = 1'b1;
              for (int i = 0; i < imu_sfp_pkg::NUM_SET; i++) begin
                if (flags_next[i] == imu_sfp_pkg::FLAG_NONE) begin
                  all_seen = 1'b0;
                end
                if (flags_next[i] != imu_sfp_pkg::FLAG_GOOD) begin
                  all_good = 1'b0;
                end
              end
              // Set complete: report and clear
              if (all_seen) begin
                res.set_done    = 1'b1;
                res.set_status  = all_good ? imu_sfp_pkg::STATUS_GOOD
                                           : imu_sfp_pkg::STATUS_DATA_ERR;
                tick_count_next = '0;
                for (int i = 0; i < imu_sfp_pkg::NUM_SET; i++) begin
                  flags_next[i] = imu_sfp_pkg::FLAG_NONE;
                end
              end
            end
          end
        end
      endcase
    end
  end

  // Parser and set state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= imu_sfp_pkg::POS_HUNT;
      cur_type   <= imu_sfp_pkg::TC_ACCEL;
      sum        <= '0;
      tick_count <= '0;
      for (int i = 0; i < imu_sfp_pkg::NUM_SET; i++) begin
        flags[i] <= imu_sfp_pkg::FLAG_NONE;
      end
    end else if (pop) begin
      pos        <= pos_next;
      cur_type   <= cur_type_next;
      sum        <= sum_next;
      tick_count <= tick_count_next;
      flags      <= flags_next;
    end
  end

  // Payload bytes
  always_ff @(posedge clk) begin
    if (pop && pay_we) begin
      payload[pay_off[2:0]] <= head_item.data;
    end
  end

  // Result register: load on a new result, drop after its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_item <= res;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/imu_serial_frame_parser.sv
// Top level of the inertial sensor serial frame parser.
// Input channel (in_valid/in_stall/in_item): one transfer per received byte
// (kind 0) or timer tick (kind 1). Output channel (out_valid/out_stall/
// out_item): one result per complete 11-byte frame and one per set timeout;
// bytes that finish no frame and ordinary ticks give no result.
// A transfer is taken on a rising edge with valid high and stall low.
// Throughput: one input per cycle while in_stall is low. Input goes into a
// 4-entry queue; the back end steps one queued item per cycle while the result
// register can take a new value. An accepted item is registered in the queue,
// and the back end then steps it and loads the result register with its result.
// When the receiver stalls, the result register holds its item; the back end
// stops stepping, the queue fills, and in_stall rises once 4 items wait.
// Reset (rst, synchronous) empties the queue and the result register, sends
// the parser back to header hunting, clears the set and tick count and
// restores timeout_ticks to 100. timeout_ticks lies at APB byte address 0.
`default_nettype none
module imu_serial_frame_parser (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire imu_sfp_pkg::in_item_t               in_item,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output imu_sfp_pkg::out_item_t                   out_item,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [imu_sfp_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [imu_sfp_pkg::PDATA_W-1:0]     pwdata,
  output logic [imu_sfp_pkg::PDATA_W-1:0]          prdata,
  output logic                                     pready
);

  logic                   q_full;
  logic                   push;
  imu_sfp_pkg::cls_item_t push_item;
  logic                   head_valid;
  imu_sfp_pkg::cls_item_t head_item;
  logic                   pop;
  logic [15:0]            timeout_ticks;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= imu_sfp_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == imu_sfp_pkg::REG_TIMEOUT)) begin
      timeout_ticks <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == imu_sfp_pkg::REG_TIMEOUT) ?
                  {16'd0, timeout_ticks} : '0;

  imu_sfp_front u_front (
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  imu_sfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  imu_sfp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .timeout_ticks (timeout_ticks),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item)
  );

endmodule
`default_nettype wire

>>> hw/rtl/imu_sfp_checker.sv
// Port-level checks for the serial frame parser, bound to the top level.
`default_nettype none
module imu_sfp_checker (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire imu_sfp_pkg::out_item_t out_item
);

  // A stalled result stays and holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Timeout results carry the fixed timeout form
  a_timeout_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.frame_type == imu_sfp_pkg::FT_NONE) |->
      out_item.set_done && !out_item.frame_ok &&
      (out_item.set_status == imu_sfp_pkg::STATUS_TIMEOUT))
    else $error("malformed timeout result");

  // A quaternion frame never completes a set
  a_quat_no_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.frame_type == imu_sfp_pkg::FT_QUAT) |-> !out_item.set_done)
    else $error("quaternion frame completed a set");

  // Status is zero unless a set is done
  a_status_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.set_done |-> (out_item.set_status == imu_sfp_pkg::STATUS_GOOD))
    else $error("set status without set done");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present after reset");

endmodule

bind imu_serial_frame_parser imu_sfp_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the inertial sensor serial frame parser.
`timescale 1ns / 1ps
module testbench;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int END_CYCLES     = 20;
  localparam logic [imu_sfp_pkg::PADDR_W-1:0] TIMEOUT_ADDR =
    imu_sfp_pkg::PADDR_W'(4 * int'(imu_sfp_pkg::REG_TIMEOUT));

  // Frame predictor and store of expected frame results
  class frame_scoreboard;
    logic [15:0]             timeout_ticks;
    logic [3:0]              parse_pos;
    logic [1:0]              cur_type;
    logic [7:0]              run_sum;
    logic [7:0]              payload [8];
    imu_sfp_pkg::flag_t      set_flags [imu_sfp_pkg::NUM_SET];
    logic [15:0]             tick_count;
    imu_sfp_pkg::out_item_t  expected_q [$];
    int                      errors;

    function new();
      timeout_ticks = imu_sfp_pkg::TIMEOUT_RESET;
      parse_pos     = imu_sfp_pkg::POS_HUNT;
      cur_type      = imu_sfp_pkg::TC_ACCEL;
      run_sum       = '0;
      foreach (payload[i]) payload[i] = '0;
      clear_set();
      errors = 0;
    endfunction

    function void clear_set();
      foreach (set_flags[i]) set_flags[i] = imu_sfp_pkg::FLAG_NONE;
      tick_count = '0;
    endfunction

    function void set_timeout(logic [15:0] value);
      timeout_ticks = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the predictor by one accepted transfer
    function void note_input(imu_sfp_pkg::in_item_t it);
      imu_sfp_pkg::out_item_t r;
      logic      ok;
      logic      known;
      logic [1:0] tc;
      r = '0;
      if (it.kind) begin
        // Tick: time out the set or count
        if (tick_count >= timeout_ticks) begin
          r.frame_type = imu_sfp_pkg::FT_NONE;
          r.set_done   = 1'b1;
          r.set_status = imu_sfp_pkg::STATUS_TIMEOUT;
          expected_q.push_back(r);
          clear_set();
        end else begin
          tick_count = tick_count + 16'd1;
        end
        return;
      end
      if (parse_pos == imu_sfp_pkg::POS_HUNT) begin
        // Drop everything but a header
        if (it.rx_byte == imu_sfp_pkg::HDR_BYTE) begin
          parse_pos = imu_sfp_pkg::POS_TYPE;
          run_sum   = imu_sfp_pkg::HDR_BYTE;
        end
      end else if (parse_pos == imu_sfp_pkg::POS_TYPE) begin
        known = 1'b1;
        tc    = imu_sfp_pkg::TC_ACCEL;
        case (it.rx_byte)
          imu_sfp_pkg::TYPE_ACCEL: tc = imu_sfp_pkg::TC_ACCEL;
          imu_sfp_pkg::TYPE_RATE:  tc = imu_sfp_pkg::TC_RATE;
          imu_sfp_pkg::TYPE_ANGLE: tc = imu_sfp_pkg::TC_ANGLE;
          imu_sfp_pkg::TYPE_QUAT:  tc = imu_sfp_pkg::TC_QUAT;
          default:                 known = 1'b0;
        endcase
        if (known) begin
          cur_type  = tc;
          run_sum   = run_sum + it.rx_byte;
          parse_pos = imu_sfp_pkg::POS_PAY_FIRST;
        end else if (it.rx_byte == imu_sfp_pkg::HDR_BYTE) begin
          // A header in the type slot restarts the frame
          parse_pos = imu_sfp_pkg::POS_TYPE;
          run_sum   = imu_sfp_pkg::HDR_BYTE;
        end else begin
          parse_pos = imu_sfp_pkg::POS_HUNT;
        end
      end else if (parse_pos <= imu_sfp_pkg::POS_PAY_LAST) begin
        payload[3'(parse_pos - imu_sfp_pkg::POS_PAY_FIRST)] = it.rx_byte;
        run_sum   = run_sum + it.rx_byte;
        parse_pos = parse_pos + 4'd1;
      end else begin
        // Checksum byte closes the frame
        ok           = (it.rx_byte == run_sum);
        parse_pos    = imu_sfp_pkg::POS_HUNT;
        r.frame_type = {1'b0, cur_type};
        r.frame_ok   = ok;
        r.word_a     = {payload[1], payload[0]};
        r.word_b     = {payload[3], payload[2]};
        r.word_c     = {payload[5], payload[4]};
        r.word_d     = {payload[7], payload[6]};
        r.set_done   = 1'b0;
        r.set_status = imu_sfp_pkg::STATUS_GOOD;
        if (cur_type != imu_sfp_pkg::TC_QUAT) begin
          set_flags[cur_type] = ok ? imu_sfp_pkg::FLAG_GOOD : imu_sfp_pkg::FLAG_BAD;
          if (set_flags[0] != imu_sfp_pkg::FLAG_NONE &&
              set_flags[1] != imu_sfp_pkg::FLAG_NONE &&
              set_flags[2] != imu_sfp_pkg::FLAG_NONE) begin
            r.set_done = 1'b1;
            if (set_flags[0] == imu_sfp_pkg::FLAG_GOOD &&
                set_flags[1] == imu_sfp_pkg::FLAG_GOOD &&
                set_flags[2] == imu_sfp_pkg::FLAG_GOOD)
              r.set_status = imu_sfp_pkg::STATUS_GOOD;
            else
              r.set_status = imu_sfp_pkg::STATUS_DATA_ERR;
            clear_set();
          end
        end
        expected_q.push_back(r);
      end
    endfunction

    // Compare one accepted result against the oldest expectation
    function void check_result(imu_sfp_pkg::out_item_t got);
      imu_sfp_pkg::out_item_t want;
      logic      bad;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: type %0d ok %0d words %h %h %h %h done %0d status %0d",
                   got.frame_type, got.frame_ok, got.word_a, got.word_b, got.word_c,
                   got.word_d, got.set_done, got.set_status);
        return;
      end
      want = expected_q.pop_front();
      bad = (got.frame_type !== want.frame_type) || (got.frame_ok !== want.frame_ok) ||
            (got.word_a !== want.word_a) || (got.word_b !== want.word_b) ||
            (got.word_c !== want.word_c) || (got.word_d !== want.word_d) ||
            (got.set_done !== want.set_done) || (got.set_status !== want.set_status);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("expected: type %0d ok %0d words %h %h %h %h done %0d status %0d",
                   want.frame_type, want.frame_ok, want.word_a, want.word_b, want.word_c,
                   want.word_d, want.set_done, want.set_status);
          $display("actual:   type %0d ok %0d words %h %h %h %h done %0d status %0d",
                   got.frame_type, got.frame_ok, got.word_a, got.word_b, got.word_c,
                   got.word_d, got.set_done, got.set_status);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  imu_sfp_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  imu_sfp_pkg::out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [imu_sfp_pkg::PADDR_W-1:0] paddr = '0;
  logic [imu_sfp_pkg::PDATA_W-1:0] pwdata = '0;
  logic [imu_sfp_pkg::PDATA_W-1:0] prdata;
  logic pready;

  frame_scoreboard sb = new();

  int sent_count = 0;
  int tick_pct = 0;
  int tick_burst_max = 1;
  bit sender_idle_en = 1'b1;
  bit out_idle_en = 1'b1;
  bit stall_off = 1'b1;
  int in_calm_left = 0;
  int out_calm_left = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  imu_serial_frame_parser dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Receiver stall: random bursts with calm stretches
  always @(posedge clk) begin
    if (stall_off) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (out_calm_left > 0) begin
      out_stall <= 1'b0;
      out_calm_left--;
    end else if ($urandom_range(0, 99) < 6) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(1, 14) - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 99) == 0) out_calm_left = $urandom_range(20, 100);
    end
  end

  // Watch both channels: predict, check, and guard against a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_item);
      if (in_valid && !in_stall) sb.note_input(in_item);
      if ((out_valid && !out_stall) || (in_valid && !in_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("imu_serial_frame_parser: mismatch");
        $finish;
      end
    end
  end

  // Offer one transfer, idling first at random, and hold it until taken
  task automatic feed(imu_sfp_pkg::in_item_t it);
    if (sender_idle_en) begin
      if (in_calm_left > 0) begin
        in_calm_left--;
      end else if ($urandom_range(0, 99) < 7) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else if ($urandom_range(0, 199) == 0) begin
        in_calm_left = $urandom_range(20, 100);
      end
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_rx(logic [7:0] b);
    feed(imu_sfp_pkg::in_item_t'{kind: 1'b0, rx_byte: b});
  endtask

  task automatic send_tick();
    feed(imu_sfp_pkg::in_item_t'{kind: 1'b1, rx_byte: 8'($urandom)});
  endtask

  task automatic maybe_tick();
    if ($urandom_range(0, 99) < tick_pct) send_tick();
  endtask

  // Four words, leaning on the signed extremes
  function automatic logic [63:0] pick_words();
    logic [63:0] w;
    for (int j = 0; j < 4; j++) begin
      case ($urandom_range(0, 7))
        0: w[16*j +: 16] = 16'h8000;
        1: w[16*j +: 16] = 16'h7FFF;
        2: w[16*j +: 16] = 16'hFFFF;
        3: w[16*j +: 16] = 16'h0000;
        default: w[16*j +: 16] = 16'($urandom);
      endcase
    end
    return w;
  endfunction

  function automatic logic [7:0] pick_type();
    int r;
    r = $urandom_range(0, 99);
    if (r < 28) return imu_sfp_pkg::TYPE_ACCEL;
    if (r < 56) return imu_sfp_pkg::TYPE_RATE;
    if (r < 84) return imu_sfp_pkg::TYPE_ANGLE;
    return imu_sfp_pkg::TYPE_QUAT;
  endfunction

  // Send the first cut bytes of a frame, with ticks mixed in
  task automatic send_frame(logic [7:0] type_byte, logic bad_cs, int cut, logic [63:0] words);
    logic [7:0] fb [11];
    logic [7:0] sum;
    fb[0] = imu_sfp_pkg::HDR_BYTE;
    fb[1] = type_byte;
    for (int j = 0; j < 4; j++) begin
      fb[2 + 2*j] = words[16*j +: 8];
      fb[3 + 2*j] = words[16*j + 8 +: 8];
    end
    sum = '0;
    for (int i = 0; i < 10; i++) sum = sum + fb[i];
    fb[10] = bad_cs ? (sum ^ 8'($urandom_range(1, 255))) : sum;
    for (int i = 0; i < cut; i++) begin
      maybe_tick();
      send_rx(fb[i]);
    end
  endtask

  // Mostly good frames; the rest noise, broken frames and tick bursts
  task automatic run_traffic(int upto);
    int r;
    logic [7:0] b;
    while (sent_count < upto) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        send_frame(pick_type(), $urandom_range(0, 7) == 0, 11, pick_words());
      end else if (r < 80) begin
        repeat ($urandom_range(1, 6)) begin
          maybe_tick();
          send_rx(8'($urandom));
        end
      end else if (r < 85) begin
        // header followed by a byte that names no frame type
        b = 8'($urandom);
        if (b == imu_sfp_pkg::TYPE_ACCEL || b == imu_sfp_pkg::TYPE_RATE ||
            b == imu_sfp_pkg::TYPE_ANGLE || b == imu_sfp_pkg::TYPE_QUAT)
          b = b ^ 8'h80;
        send_rx(imu_sfp_pkg::HDR_BYTE);
        send_rx(b);
      end else if (r < 90) begin
        send_frame(pick_type(), 1'b0, $urandom_range(2, 10), pick_words());
      end else if (r < 93) begin
        send_rx(imu_sfp_pkg::HDR_BYTE);
        send_frame(pick_type(), 1'b0, 11, pick_words());
      end else begin
        repeat ($urandom_range(1, tick_burst_max)) send_tick();
      end
    end
  endtask

  // Hold off until every result is in, let the queue empty, then write the register
  task automatic write_timeout(logic [15:0] value);
    in_valid <= 1'b0;
    stall_off = 1'b1;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TIMEOUT_ADDR;
    pwdata  <= imu_sfp_pkg::PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_timeout(value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    stall_off = !out_idle_en;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    stall_off = 1'b0;

    // Directed: noise, unknown type, header in the type slot, quaternion extremes
    tick_pct = 0;
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(imu_sfp_pkg::HDR_BYTE);
    send_rx(8'h00);
    send_rx(imu_sfp_pkg::HDR_BYTE);
    send_frame(imu_sfp_pkg::TYPE_QUAT, 1'b0, 11, 64'h0000_FFFF_7FFF_8000);
    send_tick();
    send_tick();

    // Random phases across timeout settings
    tick_pct = 8;
    tick_burst_max = 120;
    run_traffic(450);

    write_timeout(16'd1);
    tick_pct = 10;
    tick_burst_max = 4;
    run_traffic(750);

    write_timeout(16'hFFFF);
    tick_burst_max = 30;
    run_traffic(1050);

    write_timeout(16'($urandom_range(2, 40)));
    tick_burst_max = 20;
    run_traffic(1400);

    write_timeout(16'($urandom_range(41, 300)));
    tick_pct = 15;
    tick_burst_max = 150;
    run_traffic(1650);

    // Last stretch at full rate on both sides
    sender_idle_en = 1'b0;
    out_idle_en = 1'b0;
    write_timeout(16'd5);
    tick_pct = 10;
    tick_burst_max = 8;
    run_traffic(1950);

    // Drain and settle
    in_valid <= 1'b0;
    stall_off = 1'b1;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("imu_serial_frame_parser: match");
    else
      $display("imu_serial_frame_parser: mismatch");
    $finish;
  end

endmodule
